### rtl/max_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// max_priority_queue_defines.svh
// Assertion macros for the priority queue; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Invariant checked at every clock edge outside reset.
`define MPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MPQ_ASSERT_ALWAYS(lbl, expr, msg)
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, codes and the key ordering shared by the priority queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PEEK   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        value_tag;
    logic signed [31:0] priority_req;
  } req_item_t;

  typedef struct packed {
    logic [31:0]        top_tag;
    logic signed [31:0] top_priority;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } rsp_item_t;

  // One stored entry: priority, tag and insertion stamp.
  typedef struct packed {
    logic signed [31:0] prio;
    logic [31:0]        tag;
    logic [31:0]        seq;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // True when a is served before b: higher priority, then older stamp.
  function automatic logic key_before(entry_t a, entry_t b);
    logic hi;
    logic tie;
    hi  = a.prio > b.prio;
    tie = (a.prio == b.prio) && (a.seq < b.seq);
    return hi || tie;
  endfunction

endpackage

### rtl/mpq_req_if.sv
// ----------------------------------------------------------------------------
// mpq_req_if
// Request channel: operation, tag and priority with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpq_req_if;
  import mpq_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Response channel: top entry, status and count with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpq_rsp_if;
  import mpq_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max-priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                                         Per transfer
// req       in    operation, value_tag, priority_req              one operation
// rsp       out   top_tag, top_priority, status, entry_count      one result
//
// Each operation updates the chain when taken; the single response register in
// front of rsp holds its result. One transfer per cycle unless rsp stalls.
// Cell 0 always holds the entry to serve next, so peek and pop read it
// directly; insert and pop move the chain one position in the same cycle.
// Reset clears the valid flops of all cells directly, no clearing pass.
// req.ready drops only while a response waits and rsp.ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_priority_queue_defines.svh"

module max_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  mpq_req_if.sink    req,
  mpq_rsp_if.source  rsp
);
  import mpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Chain state
  entry_t              cell_q [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] here_vec;

  logic [CW-1:0] held_count;
  logic [CW-1:0] held_count_next;
  logic [31:0]   next_sequence;

  entry_t    new_entry;
  cell_ctl_t ctl;
  rsp_item_t rsp_next;

  logic accept;
  logic is_ins;
  logic is_peek;
  logic is_pop;
  logic full;
  logic empty;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_ins  = req.data.operation == OP_INSERT;
  assign is_peek = req.data.operation == OP_PEEK;
  assign is_pop  = req.data.operation == OP_POP;

  // Entries are packed at the head, so the ends tell full and empty.
  assign full  = valid_vec[CAPACITY-1];
  assign empty = !valid_vec[0];

  assign new_entry.prio = req.data.priority_req;
  assign new_entry.tag  = req.data.value_tag;
  assign new_entry.seq  = next_sequence;

  assign ctl.ins = accept && is_ins && !full;
  assign ctl.pop = accept && is_pop && !empty;

  // Cell row: each cell sees its neighbors and the broadcast command.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_v;
    logic   left_h;
    entry_t right_e;
    logic   right_v;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_v = 1'b0;
      assign left_h = 1'b0;
    end else begin : g_body
      assign left_e = cell_q[i-1];
      assign left_v = valid_vec[i-1];
      assign left_h = here_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_q[i];
      assign right_v = 1'b0;
    end else begin : g_mid
      assign right_e = cell_q[i+1];
      assign right_v = valid_vec[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_here   (left_h),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry       (cell_q[i]),
      .valid       (valid_vec[i]),
      .here        (here_vec[i])
    );
  end

  always_comb begin
    held_count_next = held_count;
    if (ctl.ins) begin
      held_count_next = held_count + CW'(1);
    end else if (ctl.pop) begin
      held_count_next = held_count - CW'(1);
    end
  end

  // Response built from the head cell before the chain moves.
  always_comb begin
    rsp_next.top_tag      = '0;
    rsp_next.top_priority = '0;
    rsp_next.status       = ST_OK;
    rsp_next.entry_count  = 7'(held_count_next);
    if (is_ins) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end
    end else if (is_peek || is_pop) begin
      if (empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        rsp_next.top_tag      = cell_q[0].tag;
        rsp_next.top_priority = cell_q[0].prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      next_sequence <= '0;
    end else begin
      held_count <= held_count_next;
      if (ctl.ins) begin
        next_sequence <= next_sequence + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data <= rsp_next;
    end
  end

  // Count tracks the number of occupied cells.
  `MPQ_ASSERT_ALWAYS(a_count_matches, $countones(valid_vec) == int'(held_count), "count mismatch")
  // Occupied cells form an unbroken run from the head.
  `MPQ_ASSERT_ALWAYS(a_packed_head, (valid_vec & (valid_vec + CAPACITY'(1))) == '0, "gap in chain")
  // A successful pop removes exactly one entry.
  `MPQ_ASSERT_NEXT(a_pop_count, ctl.pop, held_count == $past(held_count) - CW'(1), "pop count")
  // The head never ranks below its successor.
  `MPQ_ASSERT_ALWAYS(a_head_order, !valid_vec[1] || !key_before(cell_q[1], cell_q[0]), "order")

endmodule

### rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One position of the sorted chain; shifts toward the tail on insert and
// toward the head on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  mpq_pkg::cell_ctl_t ctl,
  input  mpq_pkg::entry_t    new_entry,
  input  mpq_pkg::entry_t    left_entry,
  input  logic               left_valid,
  input  logic               left_here,
  input  mpq_pkg::entry_t    right_entry,
  input  logic               right_valid,
  output mpq_pkg::entry_t    entry,
  output logic               valid,
  output logic               here
);
  import mpq_pkg::*;

  // New key belongs at or ahead of this position.
  assign here = !valid || key_before(new_entry, entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && here) begin
      valid <= left_here ? left_valid : 1'b1;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && here) begin
      entry <= left_here ? left_entry : new_entry;
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

endmodule
